### rtl/qap_pkg.sv
// shared types and constants for the quaternion attitude pid block
package qap_pkg;

    localparam int AXES     = 3;
    localparam int QW       = 16;
    localparam int DT_W     = 16;
    localparam int ERR_W    = 18;
    localparam int VEC_W    = 35;
    localparam int INT_W    = 17;
    localparam int TQ_W     = 32;
    localparam int CFG_W    = 48;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 5;
    localparam int GAIN_W   = 16;

    typedef enum logic [1:0] {
        REG_KP  = 2'd0,
        REG_KI  = 2'd1,
        REG_KD  = 2'd2,
        REG_LIM = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic hist;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0]        lim;
    } lane_gain_t;

endpackage

### rtl/qap_qmul.sv
// error quaternion: conj(current) * target, one component per cycle
module qap_qmul
    import qap_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start_i,
    input  logic signed [QW-1:0]    cur_i [4],
    input  logic signed [QW-1:0]    tgt_i [4],
    output logic                    done_o,
    output logic signed [VEC_W-1:0] vec_o [AXES]
);

    logic [1:0]              cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic signed [VEC_W-1:0] comp_reg [4];

    logic signed [QW-1:0]    b0, b1, b2, b3;
    logic [3:0]              neg;
    logic signed [2*QW-1:0]  p0, p1, p2, p3;
    logic signed [VEC_W-1:0] comp_next;

    // operand routing: component k = sum_j +/- cur_j * tgt_perm
    always_comb begin
        unique case (cnt_reg)
            2'd0: begin
                b0 = tgt_i[0]; b1 = tgt_i[1]; b2 = tgt_i[2]; b3 = tgt_i[3]; neg = 4'b0000;
            end
            2'd1: begin
                b0 = tgt_i[1]; b1 = tgt_i[0]; b2 = tgt_i[3]; b3 = tgt_i[2]; neg = 4'b0110;
            end
            2'd2: begin
                b0 = tgt_i[2]; b1 = tgt_i[3]; b2 = tgt_i[0]; b3 = tgt_i[1]; neg = 4'b1100;
            end
            default: begin
                b0 = tgt_i[3]; b1 = tgt_i[2]; b2 = tgt_i[1]; b3 = tgt_i[0]; neg = 4'b1010;
            end
        endcase
        p0 = cur_i[0] * b0;
        p1 = cur_i[1] * b1;
        p2 = cur_i[2] * b2;
        p3 = cur_i[3] * b3;
        comp_next = (neg[0] ? -VEC_W'(p0) : VEC_W'(p0))
                  + (neg[1] ? -VEC_W'(p1) : VEC_W'(p1))
                  + (neg[2] ? -VEC_W'(p2) : VEC_W'(p2))
                  + (neg[3] ? -VEC_W'(p3) : VEC_W'(p3));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            comp_reg[cnt_reg] <= comp_next;
        end
    end

    // short path: flip the vector when the scalar part is negative
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            vec_o[i] = comp_reg[0][VEC_W-1] ? -comp_reg[i+1] : comp_reg[i+1];
        end
    end

    assign done_o = done_reg;

endmodule

### rtl/qap_lane.sv
// one axis: error, clamped integral, serial derivative divide, torque sum
module qap_lane
    import qap_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lane_ctl_t               ctl_i,
    input  lane_gain_t              gain_i,
    input  logic signed [VEC_W-1:0] vec_i,
    input  logic [DT_W-1:0]         dt_i,
    output logic                    done_o,
    output logic signed [TQ_W-1:0]  torque_o
);

    localparam int NUM_W  = ERR_W + DT_W;
    localparam int EDT_W  = ERR_W + DT_W + 1;
    localparam int PT_W   = GAIN_W + ERR_W;
    localparam int IT_W   = GAIN_W + INT_W;
    localparam int DE_W   = NUM_W + 1;
    localparam int DT2_W  = GAIN_W + DE_W;
    localparam int SUM_W  = DT2_W + 4;
    localparam int INC_W  = EDT_W - 14;
    localparam int ACC_W  = INC_W + 1;

    typedef enum logic [7:0] {
        L_IDLE = 8'b00000001,
        L_ERR  = 8'b00000010,
        L_MUL1 = 8'b00000100,
        L_ACC  = 8'b00001000,
        L_MUL2 = 8'b00010000,
        L_DIV  = 8'b00100000,
        L_MUL3 = 8'b01000000,
        L_SUM  = 8'b10000000
    } lane_state_t;

    lane_state_t              state_reg;
    logic [5:0]               cnt_reg;
    logic                     done_reg;
    logic                     div_en_reg;
    logic                     neg_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  last_reg;
    logic signed [INT_W-1:0]  integ_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DT_W-1:0]          rem_reg;
    logic signed [EDT_W-1:0]  edt_reg;
    logic signed [PT_W-1:0]   pterm_reg;
    logic signed [IT_W-1:0]   iterm_reg;
    logic signed [DT2_W-1:0]  dterm_reg;
    logic signed [TQ_W-1:0]   torque_reg;

    logic signed [VEC_W-1:0]  rnd;
    logic signed [ERR_W-1:0]  e_sat;
    logic signed [ERR_W:0]    diff;
    logic [ERR_W:0]           diff_mag;
    logic signed [INC_W-1:0]  incr;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  lim_s;
    logic signed [INT_W-1:0]  acc_clamp;
    logic [DT_W:0]            rem_sh;
    logic                     q_bit;
    logic signed [DE_W-1:0]   de;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_sh;
    logic signed [TQ_W-1:0]   tq_sat;

    always_comb begin
        // round half up then saturate to the error range
        rnd = (vec_i + VEC_W'(4096)) >>> 13;
        if (rnd > VEC_W'(131071)) begin
            e_sat = 18'sh1FFFF;
        end else if (rnd < -VEC_W'(131072)) begin
            e_sat = 18'sh20000;
        end else begin
            e_sat = rnd[ERR_W-1:0];
        end
        diff     = (ERR_W+1)'(e_sat) - (ERR_W+1)'(last_reg);
        diff_mag = diff[ERR_W] ? (ERR_W+1)'(0) - diff : diff;

        incr  = INC_W'((edt_reg + EDT_W'(8192)) >>> 14);
        acc   = ACC_W'(integ_reg) + ACC_W'(incr);
        lim_s = ACC_W'({1'b0, gain_i.lim});
        if (acc > lim_s) begin
            acc_clamp = INT_W'(lim_s);
        end else if (acc < -lim_s) begin
            acc_clamp = INT_W'(-lim_s);
        end else begin
            acc_clamp = INT_W'(acc);
        end

        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, dt_i});

        if (!div_en_reg) begin
            de = '0;
        end else if (neg_reg) begin
            de = -DE_W'(num_reg);
        end else begin
            de = DE_W'(num_reg);
        end

        sum = (SUM_W'(pterm_reg) <<< 2) + SUM_W'(iterm_reg) + (SUM_W'(dterm_reg) <<< 2);
        sum_sh = (sum + SUM_W'(128)) >>> 8;
        if (sum_sh > SUM_W'(32'sh7FFFFFFF)) begin
            tq_sat = 32'sh7FFFFFFF;
        end else if (sum_sh < -SUM_W'(64'sh80000000)) begin
            tq_sat = 32'sh80000000;
        end else begin
            tq_sat = sum_sh[TQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            integ_reg <= '0;
            last_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE: begin
                    if (ctl_i.clear) begin
                        integ_reg <= '0;
                        last_reg  <= '0;
                    end else if (ctl_i.start) begin
                        state_reg <= L_ERR;
                    end
                end
                L_ERR: begin
                    err_reg    <= e_sat;
                    neg_reg    <= diff[ERR_W];
                    num_reg    <= {diff_mag[ERR_W-1:0], DT_W'(0)};
                    div_en_reg <= ctl_i.hist && (dt_i != '0);
                    state_reg  <= L_MUL1;
                end
                L_MUL1: begin
                    edt_reg   <= err_reg * $signed({1'b0, dt_i});
                    pterm_reg <= gain_i.kp * err_reg;
                    state_reg <= L_ACC;
                end
                L_ACC: begin
                    integ_reg <= acc_clamp;
                    last_reg  <= err_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= L_MUL2;
                end
                L_MUL2: begin
                    iterm_reg <= gain_i.ki * integ_reg;
                    state_reg <= L_DIV;
                end
                L_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    rem_reg <= q_bit ? DT_W'(rem_sh - {1'b0, dt_i}) : rem_sh[DT_W-1:0];
                    num_reg <= {num_reg[NUM_W-2:0], q_bit};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(NUM_W - 1)) begin
                        state_reg <= L_MUL3;
                    end
                end
                L_MUL3: begin
                    dterm_reg <= gain_i.kd * de;
                    state_reg <= L_SUM;
                end
                L_SUM: begin
                    torque_reg <= tq_sat;
                    done_reg   <= 1'b1;
                    state_reg  <= L_IDLE;
                end
                default: begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign done_o   = done_reg;
    assign torque_o = torque_reg;

endmodule

### rtl/quaternion_attitude_pid.sv
// top level: apb registers, item sequencing, axis lanes and result register
//
// Input channel s_*: one transaction carries a kind bit, the current and
// target attitude quaternions (signed Q2.14) and a time step (Q0.16).
// A compute transaction yields one torque result on m_*; a clear
// transaction zeroes the integrals and error history and yields nothing.
// Once accepted, a compute transaction passes through the quaternion
// product unit (start, then one component a cycle), then the three axis
// lanes running side by side, which include the 34-step bit-serial divide
// for the derivative, and then the output register. One transaction is in
// work at a time, so a new one is taken only once the last has finished;
// a clear leaves the block idle and ready for the next transaction.
// The result sits in an output register; the next transaction is taken
// while it waits. If the receiver stalls past the end of the following
// computation, the block holds that result and takes no new input.
// Gains and limits sit at APB byte addresses 0, 8, 16, 24; the user must
// write them only while the block is idle, which the block does not enforce.
// Reset (aresetn low, synchronous) clears state, gains, integrals, history.
module quaternion_attitude_pid
    import qap_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic signed [QW-1:0]    s_current_w,
    input  logic signed [QW-1:0]    s_current_x,
    input  logic signed [QW-1:0]    s_current_y,
    input  logic signed [QW-1:0]    s_current_z,
    input  logic signed [QW-1:0]    s_target_w,
    input  logic signed [QW-1:0]    s_target_x,
    input  logic signed [QW-1:0]    s_target_y,
    input  logic signed [QW-1:0]    s_target_z,
    input  logic [DT_W-1:0]         s_time_step,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [TQ_W-1:0]  m_torque_roll,
    output logic signed [TQ_W-1:0]  m_torque_pitch,
    output logic signed [TQ_W-1:0]  m_torque_yaw
);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_QMUL = 4'b0010,
        T_LANE = 4'b0100,
        T_HOLD = 4'b1000
    } top_state_t;

    top_state_t              state_reg;
    logic [CFG_W-1:0]        kp_reg, ki_reg, kd_reg, lim_reg;
    logic signed [QW-1:0]    cur_reg [4];
    logic signed [QW-1:0]    tgt_reg [4];
    logic [DT_W-1:0]         dt_reg;
    logic                    hist_reg;
    logic                    m_valid_reg;
    logic signed [TQ_W-1:0]  out_reg [AXES];

    logic                    accept;
    logic                    qmul_start;
    logic                    qmul_done;
    logic signed [VEC_W-1:0] vec [AXES];
    lane_ctl_t               lane_ctl;
    logic [AXES-1:0]         lane_done;
    logic signed [TQ_W-1:0]  lane_tq [AXES];
    logic                    out_free;
    logic                    out_load;

    assign pready   = 1'b1;
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == T_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (((state_reg == T_LANE) && (&lane_done)) || (state_reg == T_HOLD))
                      && out_free;

    // apb register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg  <= '0;
            ki_reg  <= '0;
            kd_reg  <= '0;
            lim_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx_t'(paddr[4:3]))
                REG_KP:  kp_reg  <= pwdata[CFG_W-1:0];
                REG_KI:  ki_reg  <= pwdata[CFG_W-1:0];
                REG_KD:  kd_reg  <= pwdata[CFG_W-1:0];
                REG_LIM: lim_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[4:3]))
            REG_KP:  prdata = APB_DW'(kp_reg);
            REG_KI:  prdata = APB_DW'(ki_reg);
            REG_KD:  prdata = APB_DW'(kd_reg);
            REG_LIM: prdata = APB_DW'(lim_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_reg[0] <= s_current_w;
            cur_reg[1] <= s_current_x;
            cur_reg[2] <= s_current_y;
            cur_reg[3] <= s_current_z;
            tgt_reg[0] <= s_target_w;
            tgt_reg[1] <= s_target_x;
            tgt_reg[2] <= s_target_y;
            tgt_reg[3] <= s_target_z;
            dt_reg     <= s_time_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            hist_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        if (s_kind) begin
                            hist_reg <= 1'b0;
                        end else begin
                            state_reg <= T_QMUL;
                        end
                    end
                end
                T_QMUL: begin
                    if (qmul_done) begin
                        state_reg <= T_LANE;
                    end
                end
                T_LANE: begin
                    if (&lane_done) begin
                        hist_reg <= 1'b1;
                        if (out_free) begin
                            state_reg <= T_IDLE;
                        end else begin
                            state_reg <= T_HOLD;
                        end
                    end
                end
                T_HOLD: begin
                    if (out_free) begin
                        state_reg <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // lanes keep their torque until the next start, so load from them directly
    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < AXES; i++) begin
                out_reg[i] <= lane_tq[i];
            end
        end
    end

    assign qmul_start     = accept && !s_kind;
    assign lane_ctl.start = qmul_done;
    assign lane_ctl.clear = accept && s_kind;
    assign lane_ctl.hist  = hist_reg;

    qap_qmul u_qmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (qmul_start),
        .cur_i   (cur_reg),
        .tgt_i   (tgt_reg),
        .done_o  (qmul_done),
        .vec_o   (vec)
    );

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        lane_gain_t gain;

        assign gain.kp  = kp_reg[GAIN_W*g +: GAIN_W];
        assign gain.ki  = ki_reg[GAIN_W*g +: GAIN_W];
        assign gain.kd  = kd_reg[GAIN_W*g +: GAIN_W];
        assign gain.lim = lim_reg[GAIN_W*g +: GAIN_W];

        qap_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl_i    (lane_ctl),
            .gain_i   (gain),
            .vec_i    (vec[g]),
            .dt_i     (dt_reg),
            .done_o   (lane_done[g]),
            .torque_o (lane_tq[g])
        );
    end

    assign m_valid        = m_valid_reg;
    assign m_torque_roll  = out_reg[0];
    assign m_torque_pitch = out_reg[1];
    assign m_torque_yaw   = out_reg[2];

endmodule
